@@ rtl/mmas_pkg.sv @@
// Shared types, constants and register codes of the moving-average scaler.
`default_nettype none
package mmas_pkg;

	localparam int LANE_COUNT = 8;
	localparam int PAIR_COUNT = LANE_COUNT / 2;

	localparam int DEF_WINDOW_DEPTH = 8;
	localparam int DEF_SAMPLE_BITS  = 12;

	localparam int IN_W   = 12;
	localparam int EXT_W  = 16;
	localparam int VOLT_W = 22;
	localparam int CURR_W = 16;

	localparam int REF_W      = 12;
	localparam int RATIO_W    = 10;
	localparam int FS_W       = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [REF_W-1:0]   REF_RESET = REF_W'(3300);
	localparam logic [RATIO_W-1:0] NUM_RESET = RATIO_W'(1);
	localparam logic [RATIO_W-1:0] DEN_RESET = RATIO_W'(1);
	localparam logic [FS_W-1:0]    FS_RESET  = FS_W'(5000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF = 2'd0,
		CFG_NUM = 2'd1,
		CFG_DEN = 2'd2,
		CFG_FS  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [IN_W-1:0] sample_0;
		logic [IN_W-1:0] sample_1;
		logic [IN_W-1:0] sample_2;
		logic [IN_W-1:0] sample_3;
		logic [IN_W-1:0] sample_4;
		logic [IN_W-1:0] sample_5;
		logic [IN_W-1:0] sample_6;
		logic [IN_W-1:0] sample_7;
	} in_t;

	typedef struct packed {
		logic [VOLT_W-1:0] voltage_0_mv;
		logic [VOLT_W-1:0] voltage_1_mv;
		logic [VOLT_W-1:0] voltage_2_mv;
		logic [VOLT_W-1:0] voltage_3_mv;
		logic [CURR_W-1:0] current_0_ma;
		logic [CURR_W-1:0] current_1_ma;
		logic [CURR_W-1:0] current_2_ma;
		logic [CURR_W-1:0] current_3_ma;
	} out_t;

	typedef struct packed {
		logic [REF_W-1:0]   ref_mv;
		logic [RATIO_W-1:0] num;
		logic [RATIO_W-1:0] den;
		logic [FS_W-1:0]    fs;
	} cfg_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic old_valid;
	} lane_ctl_t;

	typedef struct packed {
		logic start;
		logic ack;
	} scl_ctl_t;

endpackage
`default_nettype wire

@@ rtl/mmas_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module mmas_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/mmas_lane.sv @@
// One channel lane: sample history ring, running sum and average.
`default_nettype none
module mmas_lane
	import mmas_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int ADDR_W       = $clog2(WINDOW_DEPTH),
	parameter int SUM_W        = SAMPLE_BITS + $clog2(WINDOW_DEPTH),
	parameter int SHIFT        = $clog2(WINDOW_DEPTH + 1) - 1,
	parameter int AVG_W        = SUM_W - SHIFT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lane_ctl_t              ctl,
	input  wire logic [ADDR_W-1:0]      addr,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic      [AVG_W-1:0]       avg
);

	logic [SAMPLE_BITS-1:0] old_raw;
	logic [SAMPLE_BITS-1:0] old;
	logic [SUM_W-1:0]       sum_q;

	mmas_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ctl.wr),
		.re   (ctl.rd),
		.addr (addr),
		.wdata(sample),
		.rdata(old_raw)
	);

	// rows not yet written since reset read as zero
	assign old = ctl.old_valid ? old_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.wr) begin
			sum_q <= sum_q - SUM_W'(old) + SUM_W'(sample);
		end
	end

	assign avg = sum_q[SUM_W-1:SHIFT];

endmodule
`default_nettype wire

@@ rtl/mmas_scale.sv @@
// Pair scaler: voltage and current scaling with a bit-serial divider.
`default_nettype none
module mmas_scale
	import mmas_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int AVG_W       = DEF_SAMPLE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scl_ctl_t          ctl,
	input  wire cfg_t              cfg,
	input  wire logic [AVG_W-1:0]  v_avg,
	input  wire logic [AVG_W-1:0]  i_avg,
	output logic                   done,
	output logic      [VOLT_W-1:0] voltage,
	output logic      [CURR_W-1:0] current
);

	localparam int M1_W  = AVG_W + REF_W;
	localparam int CI_W  = AVG_W + FS_W;
	localparam int P_W   = M1_W + RATIO_W;
	localparam int DVD_W = P_W - SAMPLE_BITS;
	localparam int CS_W  = CI_W - SAMPLE_BITS;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int QX_W  = (DVD_W > VOLT_W) ? DVD_W : VOLT_W + 1;
	localparam int CX_W  = (CS_W > CURR_W) ? CS_W : CURR_W + 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

	typedef enum logic [3:0] {
		SC_IDLE = 4'b0001,
		SC_MUL  = 4'b0010,
		SC_DIV  = 4'b0100,
		SC_DONE = 4'b1000
	} sc_state_t;

	sc_state_t            state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [M1_W-1:0]      m1_q;
	logic [CI_W-1:0]      ci_q;
	logic [RATIO_W-1:0]   num_q;
	logic [RATIO_W-1:0]   den_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [RATIO_W-1:0]   rem_q;
	logic [P_W-1:0]       prod;
	logic [RATIO_W:0]     trial;
	logic [RATIO_W:0]     diff;
	logic                 qbit;
	logic [QX_W-1:0]      qx;
	logic [CX_W-1:0]      cx;

	assign prod  = m1_q * P_W'(den_q);
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, num_q};
	assign qbit  = (trial >= {1'b0, num_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				SC_IDLE: begin
					if (ctl.start) begin
						state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					state_q <= SC_DIV;
					cnt_q   <= '0;
				end
				SC_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= SC_DONE;
					end
				end
				SC_DONE: begin
					if (ctl.ack) begin
						state_q <= SC_IDLE;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && ctl.start) begin
			m1_q  <= v_avg * M1_W'(cfg.ref_mv);
			ci_q  <= i_avg * CI_W'(cfg.fs);
			num_q <= (cfg.num == '0) ? RATIO_W'(1) : cfg.num;
			den_q <= cfg.den;
		end
		if (state_q == SC_MUL) begin
			dvd_q <= prod[P_W-1:SAMPLE_BITS];
			rem_q <= '0;
		end
		if (state_q == SC_DIV) begin
			rem_q <= qbit ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done = (state_q == SC_DONE);

	assign qx      = QX_W'(dvd_q);
	assign cx      = CX_W'(ci_q[CI_W-1:SAMPLE_BITS]);
	assign voltage = (qx > QX_W'({VOLT_W{1'b1}})) ? '1 : qx[VOLT_W-1:0];
	assign current = (cx > CX_W'({CURR_W{1'b1}})) ? '1 : cx[CURR_W-1:0];

endmodule
`default_nettype wire

@@ rtl/multichannel_moving_average_scaler.sv @@
// Top level of the eight-channel moving-average scaler.
//
// Input channel in_valid/in_ready/in_data carries one frame of eight raw
// samples; even positions are voltages, odd positions currents. Each frame
// gives one item on out_valid/out_ready/out_data: four voltages in mV and
// four currents in mA, averaged over the last WINDOW_DEPTH frames.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while the block is idle, which it does not enforce.
// Eight lanes update their history rings and running sums in parallel; four
// pair scalers then run side by side, each with a bit-serial divider that
// retires one quotient bit per cycle. A frame is taken only while the top
// level is idle; the next one is taken once the scalers' result has been
// loaded into the output register, so frames are not overlapped.
// The finished result sits in an output register, so the next frame is
// taken while the receiver stalls; a second result waits in the scalers
// until the output register frees.
// Reset masks the history rings (read as zero until overwritten), clears
// the running sums and ring position and loads the default register values.
`default_nettype none
module multichannel_moving_average_scaler
	import mmas_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_t                       out_data,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int SHIFT  = $clog2(WINDOW_DEPTH + 1) - 1;
	localparam int AVG_W  = SUM_W - SHIFT;
	localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(WINDOW_DEPTH - 1);

	typedef enum logic [3:0] {
		T_IDLE  = 4'b0001,
		T_UPD   = 4'b0010,
		T_START = 4'b0100,
		T_WAIT  = 4'b1000
	} t_state_t;

	t_state_t          state_q;
	cfg_t              cfg_q;
	in_t               frame_q;
	out_t              out_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] pos_q;
	logic              wrapped_q;

	logic              accept;
	logic              load;
	lane_ctl_t         lane_ctl;
	scl_ctl_t          scl_ctl;
	logic [IN_W-1:0]        raw   [LANE_COUNT];
	logic [SAMPLE_BITS-1:0] samp  [LANE_COUNT];
	logic [AVG_W-1:0]       avg   [LANE_COUNT];
	logic [PAIR_COUNT-1:0]  done;
	logic [VOLT_W-1:0]      volt  [PAIR_COUNT];
	logic [CURR_W-1:0]      curr  [PAIR_COUNT];

	assign in_ready = (state_q == T_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == T_WAIT) && (&done) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_mv <= REF_RESET;
			cfg_q.num    <= NUM_RESET;
			cfg_q.den    <= DEN_RESET;
			cfg_q.fs     <= FS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_REF: cfg_q.ref_mv <= cfg_data[REF_W-1:0];
				CFG_NUM: cfg_q.num    <= cfg_data[RATIO_W-1:0];
				CFG_DEN: cfg_q.den    <= cfg_data[RATIO_W-1:0];
				CFG_FS:  cfg_q.fs     <= cfg_data[FS_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_UPD;
					end
				end
				T_UPD: begin
					state_q <= T_START;
					if (pos_q == POS_LAST) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				T_START: state_q <= T_WAIT;
				T_WAIT: begin
					if (load) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= in_data;
		end
	end

	assign raw[0] = frame_q.sample_0;
	assign raw[1] = frame_q.sample_1;
	assign raw[2] = frame_q.sample_2;
	assign raw[3] = frame_q.sample_3;
	assign raw[4] = frame_q.sample_4;
	assign raw[5] = frame_q.sample_5;
	assign raw[6] = frame_q.sample_6;
	assign raw[7] = frame_q.sample_7;

	assign lane_ctl.rd        = accept;
	assign lane_ctl.wr        = (state_q == T_UPD);
	assign lane_ctl.old_valid = wrapped_q;

	assign scl_ctl.start = (state_q == T_START);
	assign scl_ctl.ack   = load;

	for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
		logic [EXT_W-1:0] ext;

		assign ext     = EXT_W'(raw[l]);
		assign samp[l] = ext[SAMPLE_BITS-1:0];

		mmas_lane #(
			.WINDOW_DEPTH(WINDOW_DEPTH),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (lane_ctl),
			.addr  (pos_q),
			.sample(samp[l]),
			.avg   (avg[l])
		);
	end

	for (genvar p = 0; p < PAIR_COUNT; p++) begin : g_pair
		mmas_scale #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.AVG_W      (AVG_W)
		) u_scale (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (scl_ctl),
			.cfg    (cfg_q),
			.v_avg  (avg[2*p]),
			.i_avg  (avg[2*p+1]),
			.done   (done[p]),
			.voltage(volt[p]),
			.current(curr[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.voltage_0_mv <= volt[0];
			out_q.voltage_1_mv <= volt[1];
			out_q.voltage_2_mv <= volt[2];
			out_q.voltage_3_mv <= volt[3];
			out_q.current_0_ma <= curr[0];
			out_q.current_1_ma <= curr[1];
			out_q.current_2_ma <= curr[2];
			out_q.current_3_ma <= curr[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
